[hw/rtl/cpg_pkg.sv]
// shared types, constants and the cordic arctangent table for the circle point generator
package cpg_pkg;

	localparam int MAX_POINTS   = 64;
	localparam int CORDIC_STEPS = 24;
	localparam int TABLE_LEN    = 32;
	localparam int CORDIC_ITERS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

	// cordic gain compensation, 0.6072529350 in q2.30
	localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_LOAD,
		ST_ROT,
		ST_SCALE,
		ST_EMIT
	} cpg_state_t;

	// arctangent of 2^-k in phase units (2^32 is one turn)
	function automatic logic [31:0] atan_turns(input logic [4:0] k);
		logic [31:0] a;
		case (k)
			5'd0:    a = 32'h20000000;
			5'd1:    a = 32'h12E4051E;
			5'd2:    a = 32'h09FB385B;
			5'd3:    a = 32'h051111D4;
			5'd4:    a = 32'h028B0D43;
			5'd5:    a = 32'h0145D7E1;
			5'd6:    a = 32'h00A2F61E;
			5'd7:    a = 32'h00517C55;
			5'd8:    a = 32'h0028BE53;
			5'd9:    a = 32'h00145F2F;
			5'd10:   a = 32'h000A2F98;
			5'd11:   a = 32'h000517CC;
			5'd12:   a = 32'h00028BE6;
			5'd13:   a = 32'h000145F3;
			5'd14:   a = 32'h0000A2FA;
			5'd15:   a = 32'h0000517D;
			5'd16:   a = 32'h000028BE;
			5'd17:   a = 32'h0000145F;
			5'd18:   a = 32'h00000A30;
			5'd19:   a = 32'h00000518;
			5'd20:   a = 32'h0000028C;
			5'd21:   a = 32'h00000146;
			5'd22:   a = 32'h000000A3;
			5'd23:   a = 32'h00000051;
			5'd24:   a = 32'h00000029;
			5'd25:   a = 32'h00000014;
			5'd26:   a = 32'h0000000A;
			5'd27:   a = 32'h00000005;
			5'd28:   a = 32'h00000003;
			5'd29:   a = 32'h00000001;
			5'd30:   a = 32'h00000001;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

endpackage

[hw/rtl/cpg_div.sv]
// bit-serial restoring divider: one turn (2^32) divided by the point count
module cpg_div import cpg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [6:0]  divisor,
	output logic        done,
	output logic [32:0] quotient,
	output logic [6:0]  remainder
);

	logic        run_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [6:0]  den_q;
	logic [6:0]  rem_q;
	logic [32:0] quo_q;
	logic [7:0]  trial;
	logic        fits;

	// dividend is a single one at bit 32
	assign trial = {rem_q, (cnt_q == 6'd32)};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? 7'(trial - {1'b0, den_q}) : trial[6:0];
			quo_q <= {quo_q[31:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

[hw/rtl/cpg_cordic.sv]
// iterative rotation-mode cordic, one micro-rotation per cycle, with quadrant fold
module cpg_cordic import cpg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [31:0]        phase,
	output logic               done,
	output logic signed [31:0] cos_val,
	output logic signed [31:0] sin_val
);

	localparam logic [4:0] ITER_LAST = 5'(CORDIC_ITERS - 1);

	logic               run_q;
	logic               done_q;
	logic [4:0]         k_q;
	logic               flip_q;
	logic signed [33:0] x_q;
	logic signed [33:0] y_q;
	logic signed [33:0] z_q;
	logic signed [33:0] dx;
	logic signed [33:0] dy;
	logic signed [33:0] ang;
	logic               flip;
	logic [31:0]        folded;
	logic signed [33:0] x_fin;
	logic signed [33:0] y_fin;

	// phases in the second and third quarter turn are rotated by half a turn
	assign flip   = phase[31] ^ phase[30];
	assign folded = {phase[31] ^ flip, phase[30:0]};

	assign dx  = y_q >>> k_q;
	assign dy  = x_q >>> k_q;
	assign ang = $signed({2'b00, atan_turns(k_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				k_q   <= '0;
			end else if (run_q) begin
				k_q <= k_q + 5'd1;
				if (k_q == ITER_LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= GAIN_Q30;
			y_q    <= '0;
			z_q    <= $signed({{2{folded[31]}}, folded});
			flip_q <= flip;
		end else if (run_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - ang;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + ang;
			end
		end
	end

	assign x_fin   = flip_q ? -x_q : x_q;
	assign y_fin   = flip_q ? -y_q : y_q;
	assign cos_val = x_fin[31:0];
	assign sin_val = y_fin[31:0];
	assign done    = done_q;

endmodule

[hw/rtl/cpg_scale.sv]
// shared multiplier: radius times cos then sin, rounded, offset by center and saturated
module cpg_scale import cpg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [30:0]        radius,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	input  logic signed [31:0] cos_val,
	input  logic signed [31:0] sin_val,
	output logic               done,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y
);

	localparam logic [1:0] CYC_IDLE = 2'd0;
	localparam logic [1:0] CYC_X    = 2'd1;
	localparam logic [1:0] CYC_Y    = 2'd2;

	logic [1:0]         cyc_q;
	logic               done_q;
	logic signed [31:0] rad_s;
	logic signed [31:0] op;
	logic signed [63:0] prod;
	logic signed [63:0] prod_q;
	logic signed [31:0] px_q;
	logic signed [31:0] py_q;

	function automatic logic signed [31:0] round_add_sat(
		input logic signed [31:0] ctr,
		input logic signed [63:0] p
	);
		logic signed [63:0] pr;
		logic signed [33:0] off;
		logic signed [34:0] sum;
		pr  = p + 64'sd536870912;
		off = 34'(pr >>> 30);
		sum = 35'(ctr) + 35'(off);
		if (sum > 35'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (sum < -35'sd2147483648)
			return 32'sh80000000;
		else
			return sum[31:0];
	endfunction

	assign rad_s = $signed({1'b0, radius});
	assign op    = (cyc_q == CYC_IDLE) ? cos_val : sin_val;
	assign prod  = rad_s * op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyc_q  <= CYC_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (cyc_q)
				CYC_IDLE: if (start) cyc_q <= CYC_X;
				CYC_X:    cyc_q <= CYC_Y;
				CYC_Y: begin
					cyc_q  <= CYC_IDLE;
					done_q <= 1'b1;
				end
				default:  cyc_q <= CYC_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((cyc_q == CYC_IDLE && start) || cyc_q == CYC_X)
			prod_q <= prod;
		if (cyc_q == CYC_X)
			px_q <= round_add_sat(center_x, prod_q);
		if (cyc_q == CYC_Y)
			py_q <= round_add_sat(center_y, prod_q);
	end

	assign done    = done_q;
	assign point_x = px_q;
	assign point_y = py_q;

endmodule

[hw/rtl/circle_point_generator.sv]
// circle point generator: busy while it works through an accepted word
// the one-turn-by-n division runs once per word on a bit-serial divider
// each point then steps through LOAD, ROT, SCALE and EMIT, with one cordic rotation per cycle in ROT
// a word with count zero is taken while idle and gives no points
// points appear one cycle each on point_valid; the receiver cannot stall
// asynchronous active-low reset returns the sequencer to idle with busy low
module circle_point_generator import cpg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	input  logic [30:0]        radius,
	input  logic [6:0]         count,
	output logic               point_valid,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic [5:0]         point_index,
	output logic               last
);

	cpg_state_t         state_q;
	cpg_state_t         state_d;
	logic signed [31:0] cx_q;
	logic signed [31:0] cy_q;
	logic [30:0]        rad_q;
	logic [6:0]         n_q;
	logic [6:0]         n_in;
	logic [31:0]        step_q;
	logic [6:0]         srem_q;
	logic [6:0]         arem_q;
	logic [31:0]        phase_q;
	logic [5:0]         idx_q;
	logic [7:0]         rsum;
	logic               wrap;
	logic               is_last;

	logic               div_start;
	logic               div_done;
	logic [32:0]        div_quo;
	logic [6:0]         div_rem;
	logic               cord_start;
	logic               cord_done;
	logic signed [31:0] cos_val;
	logic signed [31:0] sin_val;
	logic               scale_start;
	logic               scale_done;

	assign n_in    = (count > 7'(MAX_POINTS)) ? 7'(MAX_POINTS) : count;
	assign is_last = (idx_q == 6'(n_q - 7'd1));

	// running phase floor(i * 2^32 / n) kept as quotient plus remainder
	assign rsum = {1'b0, arem_q} + {1'b0, srem_q};
	assign wrap = (rsum >= {1'b0, n_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		div_start   = 1'b0;
		cord_start  = 1'b0;
		scale_start = 1'b0;
		busy        = 1'b1;
		point_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start && n_in != 7'd0) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done)
					state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cord_start = 1'b1;
				state_d    = ST_ROT;
			end
			ST_ROT: begin
				if (cord_done) begin
					scale_start = 1'b1;
					state_d     = ST_SCALE;
				end
			end
			ST_SCALE: begin
				if (scale_done)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				point_valid = 1'b1;
				state_d     = is_last ? ST_IDLE : ST_LOAD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cx_q  <= center_x;
			cy_q  <= center_y;
			rad_q <= radius;
			n_q   <= n_in;
		end
		if (state_q == ST_DIV && div_done) begin
			step_q  <= div_quo[31:0];
			srem_q  <= div_rem;
			arem_q  <= '0;
			phase_q <= '0;
			idx_q   <= '0;
		end
		if (state_q == ST_EMIT) begin
			phase_q <= phase_q + step_q + 32'(wrap);
			arem_q  <= wrap ? 7'(rsum - {1'b0, n_q}) : rsum[6:0];
			idx_q   <= idx_q + 6'd1;
		end
	end

	cpg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.divisor   (n_in),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	cpg_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cord_start),
		.phase   (phase_q),
		.done    (cord_done),
		.cos_val (cos_val),
		.sin_val (sin_val)
	);

	cpg_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (scale_start),
		.radius   (rad_q),
		.center_x (cx_q),
		.center_y (cy_q),
		.cos_val  (cos_val),
		.sin_val  (sin_val),
		.done     (scale_done),
		.point_x  (point_x),
		.point_y  (point_y)
	);

	assign point_index = idx_q;
	assign last        = is_last;

endmodule

[hw/rtl/cpg_checker.sv]
// port-level checks for the circle point generator, bound to the top level
module cpg_checker import cpg_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [6:0] count,
	input logic       point_valid,
	input logic       last
);

	// a point only comes out of a run in progress
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid |-> busy)
		else $error("point word outside a run");

	// a zero count is taken and leaves the block idle
	a_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && count == 7'd0) |=> !busy)
		else $error("zero count started a run");

	// a nonzero count starts a run
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && count != 7'd0) |=> busy)
		else $error("nonzero count did not start a run");

	// the last point ends the run
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(point_valid && last) |=> !busy)
		else $error("run did not end after last point");

	// points are never back to back
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		(point_valid && !last) |=> !point_valid)
		else $error("point words back to back");

endmodule

bind circle_point_generator cpg_checker u_cpg_checker (.*);

[verif/circle_point_generator_test.sv]
// self-checking testbench for the circle point generator, with a point scoreboard

typedef struct {
	logic signed [31:0] x;
	logic signed [31:0] y;
	logic [5:0]         idx;
	logic               last;
} circle_point_t;

class point_board;
	localparam int     STEPS   = 24;
	localparam int     MAX_N   = 64;
	localparam longint GAIN    = 64'sd652032874;
	localparam int     MAX_LOG = 100;

	bit [31:0]     atan_q [32];
	circle_point_t due_q[$];
	int            errors;

	function new();
		atan_q = '{
			32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
			32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
			32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
			32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
			32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
			32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
			32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
			32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
		errors = 0;
	endfunction

	function int pending();
		return due_q.size();
	endfunction

	// cos and sin in q2.30 of a phase where 2^32 is one turn
	function void cos_sin(input bit [31:0] phase, output longint c, output longint s);
		bit        flip;
		bit [31:0] p;
		longint    x, y, z, dx, dy;
		flip = (phase >= 32'h40000000) && (phase < 32'hC0000000);
		p = flip ? phase - 32'h80000000 : phase;
		z = longint'($signed(p));
		x = GAIN;
		y = 0;
		for (int k = 0; k < STEPS; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= longint'(atan_q[k]);
			end else begin
				x += dx;
				y -= dy;
				z += longint'(atan_q[k]);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function logic signed [31:0] offset_sat(input longint ctr, input longint r,
			input longint trig);
		longint v;
		v = ctr + ((r * trig + (64'sd1 <<< 29)) >>> 30);
		if (v > 64'sd2147483647)
			v = 64'sd2147483647;
		else if (v < -64'sd2147483648)
			v = -64'sd2147483648;
		return v[31:0];
	endfunction

	// expected points of one accepted word
	function void note_word(input logic signed [31:0] cx, input logic signed [31:0] cy,
			input logic [30:0] r, input logic [6:0] n_in);
		int            n;
		bit [63:0]     num;
		bit [31:0]     phase;
		longint        c, s;
		circle_point_t pt;
		n = (n_in > MAX_N) ? MAX_N : int'(n_in);
		for (int i = 0; i < n; i++) begin
			num = 64'(i) << 32;
			phase = 32'(num / 64'(n));
			cos_sin(phase, c, s);
			pt.x = offset_sat(longint'(cx), longint'(r), c);
			pt.y = offset_sat(longint'(cy), longint'(r), s);
			pt.idx = 6'(i);
			pt.last = (i + 1 == n);
			due_q.push_back(pt);
		end
	endfunction

	task report(input string what, input longint got, input longint want);
		if (errors < MAX_LOG)
			$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	task check_point(input logic signed [31:0] px, input logic signed [31:0] py,
			input logic [5:0] idx, input logic lst);
		circle_point_t pt;
		if (due_q.size() == 0) begin
			report("point with nothing pending, index", idx, -1);
		end else begin
			pt = due_q.pop_front();
			if (px !== pt.x)
				report("point_x", px, pt.x);
			if (py !== pt.y)
				report("point_y", py, pt.y);
			if (idx !== pt.idx)
				report("point_index", idx, pt.idx);
			if (lst !== pt.last)
				report("last", lst, pt.last);
		end
	endtask
endclass

module circle_point_generator_test;
	localparam int     RANDOM_WORDS = 350;
	localparam longint CYCLE_LIMIT  = 4000000;
	localparam int     DRAIN_CYCLES = 2100;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] center_x;
	logic signed [31:0] center_y;
	logic [30:0]        radius;
	logic [6:0]         count;
	logic               point_valid;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic [5:0]         point_index;
	logic               last;

	point_board board = new();
	longint     cycles = 0;
	bit         no_idle = 0;

	circle_point_generator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.center_x    (center_x),
		.center_y    (center_y),
		.radius      (radius),
		.count       (count),
		.point_valid (point_valid),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_index (point_index),
		.last        (last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && point_valid)
			board.check_point(point_x, point_y, point_index, last);
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (no_idle || roll < 40)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 95)
			return $urandom_range(4, 20);
		return $urandom_range(50, 300);
	endfunction

	function automatic logic signed [31:0] pick_center();
		case ($urandom_range(0, 5))
			0: return 32'sd0;
			1: return $signed($urandom_range(0, 2097152)) - 32'sd1048576;
			2: return 32'sh7FFFFFFF - $signed($urandom_range(0, 65536));
			3: return 32'sh80000000 + $signed($urandom_range(0, 65536));
			default: return $signed($urandom);
		endcase
	endfunction

	function automatic logic [30:0] pick_radius();
		case ($urandom_range(0, 5))
			0: return 31'd0;
			1: return 31'($urandom_range(0, 1048576));
			2: return 31'h7FFFFFFF - 31'($urandom_range(0, 65536));
			default: return 31'($urandom);
		endcase
	endfunction

	// mostly short runs so the whole pass stays quick
	function automatic logic [6:0] pick_count();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			return 7'd0;
		if (roll < 65)
			return 7'($urandom_range(1, 8));
		if (roll < 85)
			return 7'($urandom_range(9, 32));
		if (roll < 95)
			return 7'($urandom_range(33, 64));
		return 7'($urandom_range(65, 127));
	endfunction

	// start stays high across back-to-back words, so it is only lowered for a gap
	task automatic send_word(input logic signed [31:0] cx, input logic signed [31:0] cy,
			input logic [30:0] r, input logic [6:0] n);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start    <= 1'b1;
		center_x <= cx;
		center_y <= cy;
		radius   <= r;
		count    <= n;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_word(cx, cy, r, n);
	endtask

	initial begin
		arst_n   = 1'b0;
		start    = 1'b0;
		center_x = '0;
		center_y = '0;
		radius   = '0;
		count    = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed words
		send_word(32'sd0, 32'sd0, 31'h00010000, 7'd1);
		send_word(32'sd0, 32'sd0, 31'h00010000, 7'd2);
		send_word(32'sd65536, -32'sd65536, 31'h00030000, 7'd3);
		send_word(32'sd0, 32'sd0, 31'h00010000, 7'd4);
		send_word(32'sd0, 32'sd0, 31'h7FFFFFFF, 7'd64);
		send_word(32'sd123, 32'sd456, 31'h00050000, 7'd0);
		send_word(32'sd0, 32'sd0, 31'h00020000, 7'd65);
		send_word(-32'sd1000, 32'sd1000, 31'h00200000, 7'd127);
		send_word(32'sh12345678, 32'sh87654321, 31'd0, 7'd5);
		send_word(32'sd0, 32'sd0, 31'h7FFFFFFF, 7'd8);
		// saturation on both sides
		send_word(32'sh7FFFFFFF, 32'sh7FFFFFFF, 31'h7FFFFFFF, 7'd4);
		send_word(32'sh80000000, 32'sh80000000, 31'h7FFFFFFF, 7'd4);
		send_word(32'sh7FFFFFFF, 32'sh80000000, 31'h7FFFFFFF, 7'd7);
		send_word(-32'sd1, -32'sd1, 31'd1, 7'd6);
		send_word(32'sd0, 32'sd0, 31'h55555555, 7'd12);
		send_word(32'shAAAAAAAA, 32'sh55555555, 31'h2AAAAAAA, 7'd63);
		send_word(32'sd0, 32'sd0, 31'd3, 7'd1);
		send_word(32'sd0, 32'sd0, 31'd0, 7'd0);

		for (int k = 0; k < RANDOM_WORDS; k++) begin
			if (k % 40 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			send_word(pick_center(), pick_center(), pick_radius(), pick_count());
		end
		@(negedge clk);
		start <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
